/* sv/sfd_pkg.sv */
// Package with shared types and constants of the sync frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package sfd_pkg;
	localparam int FrameBytes = 64;
	localparam int PosW = $clog2(FrameBytes + 1);
	localparam int AddrW = $clog2(FrameBytes);

	typedef enum logic [1:0] {
		KIND_LEN_ERR = 2'd0,
		KIND_CS_FAIL = 2'd1,
		KIND_OTHER   = 2'd2,
		KIND_CHANNEL = 2'd3
	} kind_t;

	localparam logic [7:0] SYNC_A = 8'hFF;
	localparam logic [7:0] SYNC_B = 8'hFB;
	localparam logic [7:0] MAIN_TYPE = 8'h10;
	localparam logic [7:0] MAIN_LEN = 8'h15;
	localparam int MainTotal = 25;
	localparam int MinTotal = 7;
	localparam int ChanBase = 12;
	localparam logic [15:0] DB_MAX = 16'd65471;

	localparam logic [2:0] REG_DEADBAND = 3'd5;

	localparam logic [47:0] CAL_RESET [5] = '{
		48'd8590033093608, 48'd8590031979496, 48'd8590032438248,
		48'd8590033617902, 48'd8590032765928
	};
	localparam logic [15:0] DB_RESET = 16'd1966;
endpackage
`default_nettype wire

/* sv/sfd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sfd_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* sv/sfd_div.sv */
// Restoring divider producing a 17-bit quotient, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module sfd_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [47:0] den,
	output logic             busy,
	output logic [16:0]      quo
);
	logic [63:0] rem_q;
	logic [4:0] cnt_q;
	logic [47:0] den_q;
	logic [64:0] trial;
	logic [64:0] shd;

	assign busy = (cnt_q != 5'd0);
	always_comb begin
		shd = {17'd0, den_q} << (cnt_q - 5'd1);
		trial = {1'b0, rem_q} - shd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (start) begin
			cnt_q <= 5'd17;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo <= 17'd0;
		end else if (busy) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo <= {quo[15:0], 1'b1};
			end else begin
				quo <= {quo[15:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

/* sv/sync_frame_decoder_axis_normalizer.sv */
// Top level of the sync frame decoder with channel normalizer.
// Bytes enter on the s_axis channel, one per transaction. The decoder hunts
// for the sync pair FF FB, stores the frame in a 64-entry RAM and, at the
// last byte, produces one result, or six channel results for a main frame.
// Results leave on m_axis; tlast marks the final result of one input byte.
// tuser carries the result kind; a bad length byte yields a length error.
// A byte that ends no frame is taken straight in the idle state. A frame
// end walks the RAM once for the checksum, reading and then accumulating
// each byte, then per channel reads two bytes and, for each normalized
// channel, runs a 17-step divider. s_axis_tready is low while a frame end
// is processed or a result waits. When the receiver stalls, the result
// holds in the output register and processing waits. Reset clears the
// parser, counters and registers to their reset values; the RAM content
// is not cleared and is always written within a frame before it is read.
// Calibration writes use the APB port.
`timescale 1ns / 1ps
`default_nettype none
module sync_frame_decoder_axis_normalizer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // byte_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// frame_type, length_byte, channel, raw_value, normalized,
	// frame_count, valid_count, invalid_count, main_count (then zero pad)
	output logic [183:0]     m_axis_tdata,
	output logic             m_axis_tlast,
	output logic [1:0]       m_axis_tuser,   // kind
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import sfd_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_CSRD  = 11'b00000000010,
		ST_CSACC = 11'b00000000100,
		ST_DECID = 11'b00000001000,
		ST_RLO   = 11'b00000010000,
		ST_RHI   = 11'b00000100000,
		ST_NPREP = 11'b00001000000,
		ST_NPRD  = 11'b00010000000,
		ST_NDIV  = 11'b00100000000,
		ST_EMIT  = 11'b01000000000,
		ST_HDR   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [47:0] cal_q [5];
	logic [15:0] db_q;
	logic sync_q;
	logic [PosW-1:0] pos_q, exp_q;
	logic [7:0] type_q, lb_q, cs_q, last_q, rlo_q;
	logic [PosW-1:0] idx_q;
	logic [2:0] ch_q;
	logic [15:0] raw_q;
	logic [31:0] tot_q, val_q, inv_q, mn_q;
	logic neg_q, zero_q;
	logic [16:0] nv_q;

	logic we;
	logic [AddrW-1:0] waddr, raddr;
	logic [7:0] wdata, rdata;

	sfd_ram #(.Width(8), .Depth(FrameBytes)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// APB
	logic wr;
	logic [2:0] ridx;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign ridx = paddr[5:3];
	always_comb begin
		prdata = '0;
		if (ridx < REG_DEADBAND) prdata = {16'd0, cal_q[ridx]};
		else if (ridx == REG_DEADBAND) prdata = {48'd0, db_q};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) cal_q[i] <= CAL_RESET[i];
			db_q <= DB_RESET;
		end else if (wr) begin
			if (ridx < REG_DEADBAND) cal_q[ridx] <= pwdata[47:0];
			else if (ridx == REG_DEADBAND) db_q <= pwdata[15:0];
		end
	end

	// normalization helpers
	logic [47:0] cal;
	logic [15:0] lo, mid, hi, n0, d, n;
	logic calok, neg;
	logic [32:0] nsh, dbd;
	logic [63:0] dnum;
	logic [47:0] dden;
	logic [32:0] num33;
	logic [32:0] den33;
	logic div_start, div_busy;
	logic div_go, dstart_q;
	logic [16:0] div_q;
	logic [32:0] num_q, den_q;

	always_comb begin
		cal = cal_q[ch_q < 3'd5 ? ch_q : 3'd0];
		lo = cal[15:0];
		mid = cal[31:16];
		hi = cal[47:32];
		calok = (lo < mid) && (mid < hi);
		neg = raw_q < mid;
		n0 = neg ? mid - raw_q : raw_q - mid;
		d = neg ? mid - lo : hi - mid;
		n = (n0 > d) ? d : n0;
		nsh = {1'b0, n, 16'd0};
		dbd = 33'(db_q) * 33'(d);
		num33 = nsh - dbd;
		den33 = 33'(d) * 33'(17'h10000 - {1'b0, db_q});
		dnum = {16'd0, num_q[31:0], 16'd0} + 64'(den_q);
		dden = {14'd0, den_q, 1'b0};
	end

	sfd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(dnum),
		.den(dden), .busy(div_busy), .quo(div_q)
	);

	logic [15:0] qsat, nout;
	always_comb begin
		qsat = (nv_q > 17'd32767) ? 16'd32767 : nv_q[15:0];
		nout = zero_q ? 16'd0 : (neg_q ? 16'(-qsat) : qsat);
	end

	logic acc_in, acc_out;
	assign acc_in = s_axis_tvalid && s_axis_tready;
	assign acc_out = m_axis_tvalid && m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;

	logic [PosW-1:0] pos_n;
	logic [8:0] exp_n;
	always_comb begin
		pos_n = pos_q + PosW'(1);
		exp_n = {1'b0, s_axis_tdata} + 9'd4;
	end

	always_comb begin
		we = acc_in && (pos_q != '0) && (pos_q < PosW'(FrameBytes));
		waddr = pos_q[AddrW-1:0];
		wdata = s_axis_tdata;
		raddr = idx_q[AddrW-1:0];
		div_go = calok && (ch_q != 3'd5) && (nsh > dbd) && (db_q < DB_MAX);
		div_start = dstart_q;
	end

	// output register
	logic [1:0] okind_q;
	logic [7:0] otype_q, olb_q;
	logic [2:0] och_q;
	logic [15:0] oraw_q, onorm_q;
	logic olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sync_q <= 1'b0;
			pos_q <= '0;
			exp_q <= '0;
			tot_q <= '0;
			val_q <= '0;
			inv_q <= '0;
			mn_q <= '0;
			dstart_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (acc_out) m_axis_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (pos_q == '0) begin
							if (!sync_q) sync_q <= (s_axis_tdata == SYNC_A);
							else if (s_axis_tdata == SYNC_B) begin
								pos_q <= PosW'(2);
								sync_q <= 1'b0;
							end else sync_q <= (s_axis_tdata == SYNC_A);
						end else if (pos_q >= PosW'(FrameBytes)) begin
							inv_q <= inv_q + 32'd1;
							okind_q <= KIND_LEN_ERR; otype_q <= '0; olb_q <= lb_q;
							och_q <= '0; oraw_q <= '0; onorm_q <= '0; olast_q <= 1'b1;
							m_axis_tvalid <= 1'b1;
							pos_q <= '0; exp_q <= '0; sync_q <= 1'b0;
						end else begin
							if (pos_q == PosW'(2)) type_q <= s_axis_tdata;
							if (pos_q == PosW'(3)) begin
								lb_q <= s_axis_tdata;
								if (exp_n < 9'(MinTotal) || exp_n > 9'(FrameBytes)) begin
									inv_q <= inv_q + 32'd1;
									okind_q <= KIND_LEN_ERR; otype_q <= '0;
									olb_q <= s_axis_tdata; och_q <= '0; oraw_q <= '0;
									onorm_q <= '0; olast_q <= 1'b1;
									m_axis_tvalid <= 1'b1;
									pos_q <= '0; exp_q <= '0; sync_q <= 1'b0;
								end else begin
									pos_q <= pos_n;
									exp_q <= exp_n[PosW-1:0];
								end
							end else if (exp_q != '0 && pos_n == exp_q) begin
								last_q <= s_axis_tdata;
								tot_q <= tot_q + 32'd1;
								cs_q <= '0;
								idx_q <= PosW'(6);
								state_q <= ST_CSRD;
								pos_q <= '0; sync_q <= 1'b0;
							end else pos_q <= pos_n;
						end
					end
				end
				ST_CSRD: begin
					if (idx_q + PosW'(1) < exp_q) begin
						idx_q <= idx_q + PosW'(1);
						state_q <= ST_CSACC;
					end else state_q <= ST_DECID;
				end
				ST_CSACC: begin
					cs_q <= cs_q ^ rdata;
					state_q <= ST_CSRD;
				end
				ST_DECID: begin
					if (exp_q == PosW'(MinTotal) || cs_q != last_q) begin
						inv_q <= inv_q + 32'd1;
						okind_q <= KIND_CS_FAIL;
						state_q <= ST_HDR;
					end else if (type_q == MAIN_TYPE && lb_q == MAIN_LEN &&
						exp_q == PosW'(MainTotal)) begin
						val_q <= val_q + 32'd1;
						mn_q <= mn_q + 32'd1;
						ch_q <= '0;
						idx_q <= PosW'(ChanBase);
						state_q <= ST_RLO;
					end else begin
						val_q <= val_q + 32'd1;
						okind_q <= KIND_OTHER;
						state_q <= ST_HDR;
					end
					exp_q <= '0;
				end
				ST_HDR: begin
					otype_q <= type_q; olb_q <= lb_q; och_q <= '0; oraw_q <= '0;
					onorm_q <= '0; olast_q <= 1'b1;
					m_axis_tvalid <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RLO: begin
					idx_q <= idx_q + PosW'(1);
					state_q <= ST_RHI;
				end
				ST_RHI: begin
					rlo_q <= rdata;
					idx_q <= idx_q + PosW'(1);
					state_q <= ST_NPRD;
				end
				ST_NPRD: begin
					raw_q <= {rdata, rlo_q};
					state_q <= ST_NPREP;
				end
				ST_NPREP: begin
					neg_q <= neg;
					num_q <= num33;
					den_q <= den33;
					zero_q <= !div_go;
					dstart_q <= div_go;
					nv_q <= '0;
					state_q <= div_go ? ST_NDIV : ST_EMIT;
				end
				ST_NDIV: begin
					if (dstart_q) dstart_q <= 1'b0;
					else if (!div_busy) begin
						nv_q <= div_q;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_axis_tvalid) begin
						okind_q <= KIND_CHANNEL; otype_q <= type_q; olb_q <= lb_q;
						och_q <= ch_q; oraw_q <= raw_q; onorm_q <= nout;
						olast_q <= (ch_q == 3'd5);
						m_axis_tvalid <= 1'b1;
						if (ch_q == 3'd5) state_q <= ST_IDLE;
						else begin
							ch_q <= ch_q + 3'd1;
							state_q <= ST_RLO;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tuser = okind_q;
	assign m_axis_tlast = olast_q;
	assign m_axis_tdata = {5'd0, mn_q, inv_q, val_q, tot_q, onorm_q, oraw_q, och_q,
		olb_q, otype_q};

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> !s_axis_tready;
	endproperty
	assert property (p_no_accept_busy) else $error("accept while busy");

	property p_valid_holds;
		@(posedge clk) disable iff (!arst_n)
			(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid;
	endproperty
	assert property (p_valid_holds) else $error("result dropped");

	property p_pos_range;
		@(posedge clk) disable iff (!arst_n) pos_q <= PosW'(FrameBytes);
	endproperty
	assert property (p_pos_range) else $error("position out of range");
endmodule
`default_nettype wire

/* test/sfd_checker.sv */
// Checker that predicts decoder results from accepted bytes and compares them.
`timescale 1ns / 1ps
module sfd_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [183:0] m_axis_tdata,
	input  wire logic         m_axis_tlast,
	input  wire logic [1:0]   m_axis_tuser,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [5:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output int                fail_count,
	output int                pending
);
	import sfd_pkg::*;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  ftype;
		logic [7:0]  lbyte;
		logic [2:0]  chan;
		logic [15:0] raw;
		logic [15:0] norm;
		logic        last;
		logic [31:0] n_total;
		logic [31:0] n_valid;
		logic [31:0] n_invalid;
		logic [31:0] n_main;
	} frame_result_t;

	frame_result_t result_q[$];
	logic [47:0] cal[5];
	logic [15:0] dband;
	logic        ff_seen;
	int          pos;
	int          tot_len;
	logic [7:0]  fbuf[FrameBytes];
	logic [31:0] cnt_total, cnt_valid, cnt_invalid, cnt_main;

	assign pending = result_q.size();

	function automatic logic [15:0] norm_q15(logic [15:0] raw, logic [47:0] c);
		longint unsigned lo, mid, hi, n, d, num, den, q;
		logic neg;
		lo = c[15:0];
		mid = c[31:16];
		hi = c[47:32];
		if (!(lo < mid && mid < hi))
			return 16'd0;
		neg = raw < mid;
		if (neg) begin
			n = mid - raw;
			d = mid - lo;
		end else begin
			n = raw - mid;
			d = hi - mid;
		end
		if (n > d)
			n = d;
		if (n * 65536 <= longint'(dband) * d || dband >= DB_MAX)
			return 16'd0;
		num = n * 65536 - longint'(dband) * d;
		den = d * (65536 - longint'(dband));
		q = (num * 65536 + den) / (2 * den);
		if (q > 32767)
			q = 32767;
		return neg ? 16'(-q) : 16'(q);
	endfunction

	function automatic frame_result_t make_result(logic [1:0] k, logic [7:0] ty,
			logic [7:0] lb, logic [2:0] ch, logic [15:0] raw, logic [15:0] nv,
			logic lst);
		return '{k, ty, lb, ch, raw, nv, lst, cnt_total, cnt_valid, cnt_invalid,
			cnt_main};
	endfunction

	task automatic close_frame();
		logic [7:0] xs;
		logic       ok;
		logic [15:0] raw;
		ok = 1'b0;
		xs = 8'd0;
		cnt_total++;
		if (tot_len > MinTotal && tot_len <= FrameBytes) begin
			for (int i = 6; i + 1 < tot_len; i++)
				xs ^= fbuf[i];
			ok = xs == fbuf[tot_len-1];
		end
		if (!ok) begin
			cnt_invalid++;
			result_q.push_back(make_result(KIND_CS_FAIL, fbuf[2], fbuf[3], 0, 0, 0, 1));
		end else begin
			cnt_valid++;
			if (fbuf[2] == MAIN_TYPE && fbuf[3] == MAIN_LEN && tot_len == MainTotal) begin
				cnt_main++;
				for (int i = 0; i < 6; i++) begin
					raw = {fbuf[ChanBase+2*i+1], fbuf[ChanBase+2*i]};
					result_q.push_back(make_result(KIND_CHANNEL, fbuf[2], fbuf[3], 3'(i),
						raw, (i < 5) ? norm_q15(raw, cal[i]) : 16'd0, i == 5));
				end
			end else begin
				result_q.push_back(make_result(KIND_OTHER, fbuf[2], fbuf[3], 0, 0, 0, 1));
			end
		end
		pos = 0;
		tot_len = 0;
		ff_seen = 0;
	endtask

	task automatic take_byte(logic [7:0] b);
		if (pos == 0) begin
			if (!ff_seen)
				ff_seen = b == SYNC_A;
			else if (b == SYNC_B) begin
				fbuf[0] = SYNC_A;
				fbuf[1] = SYNC_B;
				pos = 2;
				ff_seen = 0;
			end else
				ff_seen = b == SYNC_A;
			return;
		end
		if (pos >= FrameBytes) begin
			cnt_invalid++;
			result_q.push_back(make_result(KIND_LEN_ERR, 0, fbuf[3], 0, 0, 0, 1));
			pos = 0;
			tot_len = 0;
			ff_seen = 0;
			return;
		end
		fbuf[pos] = b;
		pos++;
		if (pos == 4) begin
			tot_len = 4 + b;
			if (tot_len < MinTotal || tot_len > FrameBytes) begin
				cnt_invalid++;
				result_q.push_back(make_result(KIND_LEN_ERR, 0, b, 0, 0, 0, 1));
				pos = 0;
				tot_len = 0;
				ff_seen = 0;
				return;
			end
		end
		if (tot_len != 0 && pos == tot_len)
			close_frame();
	endtask

	task automatic compare(frame_result_t got);
		frame_result_t exp_r;
		if (result_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("Unexpected result %h", got);
			return;
		end
		exp_r = result_q.pop_front();
		if (got !== exp_r) begin
			fail_count++;
			if (fail_count <= 10)
				$display("Mismatch: kind %0d/%0d type %h/%h len %h/%h ch %0d/%0d raw %h/%h norm %h/%h last %b/%b cnt %h/%h",
					exp_r.kind, got.kind, exp_r.ftype, got.ftype, exp_r.lbyte, got.lbyte,
					exp_r.chan, got.chan, exp_r.raw, got.raw, exp_r.norm, got.norm,
					exp_r.last, got.last,
					{exp_r.n_total, exp_r.n_valid, exp_r.n_invalid, exp_r.n_main},
					{got.n_total, got.n_valid, got.n_invalid, got.n_main});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++)
				cal[i] = CAL_RESET[i];
			dband = DB_RESET;
			ff_seen = 0;
			pos = 0;
			tot_len = 0;
			cnt_total = 0;
			cnt_valid = 0;
			cnt_invalid = 0;
			cnt_main = 0;
			fail_count = 0;
			result_q.delete();
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[5:3] < REG_DEADBAND)
					cal[paddr[5:3]] = pwdata[47:0];
				else if (paddr[5:3] == REG_DEADBAND)
					dband = pwdata[15:0];
			end
			if (m_axis_tvalid && m_axis_tready)
				compare('{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
					m_axis_tdata[18:16], m_axis_tdata[34:19], m_axis_tdata[50:35],
					m_axis_tlast, m_axis_tdata[82:51], m_axis_tdata[114:83],
					m_axis_tdata[146:115], m_axis_tdata[178:147]});
			if (s_axis_tvalid && s_axis_tready)
				take_byte(s_axis_tdata);
		end
	end
endmodule

/* test/tb_sync_frame_decoder_axis_normalizer.sv */
// Testbench top: drives bytes, calibration writes and output stalls, then gives the verdict.
`timescale 1ns / 1ps
module tb_sync_frame_decoder_axis_normalizer;
	import sfd_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [183:0] m_axis_tdata;
	logic         m_axis_tlast;
	logic [1:0]   m_axis_tuser;
	logic         psel, penable, pwrite;
	logic [5:0]   paddr;
	logic [63:0]  pwdata, prdata;
	logic         pready;
	int           fail_count, pending, idle_cycles;
	int           stall_mode;
	logic [7:0]   byte_q[$];

	sync_frame_decoder_axis_normalizer u_dut (.*);

	sfd_checker u_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (stall_mode == 0)
			m_axis_tready <= 1'b1;
		else if (stall_mode == 1)
			m_axis_tready <= $urandom_range(0, 3) != 0;
		else
			m_axis_tready <= $urandom_range(0, 3) == 0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic reg_write(int idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 6'(8 * idx);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_queued();
		int burst;
		int gap;
		burst = 0;
		while (byte_q.size() > 0) begin
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
				if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap)
						@(posedge clk);
				end
				burst = $urandom_range(1, 16);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= byte_q[0];
			@(posedge clk);
			while (!s_axis_tready)
				@(posedge clk);
			void'(byte_q.pop_front());
			burst--;
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (200)
			@(posedge clk);
	endtask

	task automatic queue_frame(logic [7:0] ftype, int total, bit good_cs, bit chan_edges);
		logic [7:0] fr[];
		logic [7:0] xs;
		fr = new[total];
		fr[0] = SYNC_A;
		fr[1] = SYNC_B;
		fr[2] = ftype;
		fr[3] = 8'(total - 4);
		xs = 8'd0;
		for (int i = 4; i < total - 1; i++) begin
			fr[i] = 8'($urandom_range(0, 255));
			if (i >= ChanBase && i < ChanBase + 12) begin
				if (chan_edges)
					fr[i] = (i % 2) ? 8'($urandom_range(0, 255) & 8'h8F) : fr[i];
				else if (i % 2)
					fr[i] = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(3, 8));
			end
			if (i >= 6)
				xs ^= fr[i];
		end
		fr[total-1] = good_cs ? xs : 8'($urandom_range(0, 255));
		foreach (fr[i])
			byte_q.push_back(fr[i]);
	endtask

	function automatic logic [47:0] rand_cal();
		logic [15:0] lo, mid, hi;
		if ($urandom_range(0, 7) == 0)
			return {$urandom(), 16'($urandom())};
		lo = 16'($urandom_range(0, 3000));
		mid = lo + 16'($urandom_range(1, 1500));
		hi = mid + 16'($urandom_range(1, 1500));
		return {hi, mid, lo};
	endfunction

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stall_mode = 0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;

		byte_q = '{8'h00, 8'hFF, 8'hFF, 8'hFB, 8'h10, 8'h02};
		queue_frame(MAIN_TYPE, MainTotal, 1, 0);
		queue_frame(MAIN_TYPE, MainTotal, 0, 0);
		queue_frame(8'h22, 7, 1, 0);
		queue_frame(8'h33, 8, 1, 0);
		queue_frame(8'h44, FrameBytes, 1, 0);
		byte_q.push_back(SYNC_A);
		byte_q.push_back(SYNC_B);
		byte_q.push_back(8'h10);
		byte_q.push_back(8'hFF);
		send_queued();
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			stall_mode = phase % 3;
			for (int c = 0; c < 5; c++)
				reg_write(c, phase == 0 ? 64'({16'hFFFF, 16'h8000, 16'h0000})
					: phase == 1 ? 64'({16'd2000, 16'd1500, 16'd1000}) : 64'(rand_cal()));
			reg_write(REG_DEADBAND, phase == 0 ? 64'd0 : phase == 1 ? 64'd32768
				: phase == 2 ? 64'd65535 : phase == 3 ? 64'd65470
				: 64'($urandom_range(0, 32768)));
			reg_write(6, 64'd0);
			for (int f = 0; f < 2; f++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: queue_frame(MAIN_TYPE, MainTotal, 1, phase == 0);
					5: queue_frame(MAIN_TYPE, MainTotal, 0, 0);
					6: queue_frame(8'($urandom_range(0, 255)), $urandom_range(7, FrameBytes),
						$urandom_range(0, 1) != 0, 0);
					7: begin
						byte_q.push_back(SYNC_A);
						byte_q.push_back(SYNC_B);
						byte_q.push_back(8'($urandom_range(0, 255)));
						byte_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 2))
							: 8'($urandom_range(61, 255)));
					end
					default: repeat ($urandom_range(1, 6))
						byte_q.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			send_queued();
			drain();
		end

		stall_mode = 1;
		reg_write(REG_DEADBAND, 64'd1966);
		for (int f = 0; f < 2; f++) begin
			if ($urandom_range(0, 3) != 0)
				queue_frame(MAIN_TYPE, MainTotal, $urandom_range(0, 5) != 0, 0);
			else
				queue_frame(8'($urandom_range(0, 255)), $urandom_range(7, 30), 1, 0);
			stall_mode = $urandom_range(0, 2);
			send_queued();
		end
		drain();

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
